/* hw/rtl/lbm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the D2Q9 node update.
package lbm_pkg;

  localparam int NDIR       = 9;
  localparam int WORD_W     = 20;
  localparam int OMEGA_W    = 17;
  localparam int OMEGA_FRAC = 16;
  localparam int VEL_W      = WORD_W + 2;
  localparam int MOM_W      = WORD_W + 3;
  localparam int SUM_W      = WORD_W + 4;
  localparam int ACC_W      = 48;

  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 17'd65536;

  localparam logic signed [WORD_W-1:0] SAT_MAX = 20'sd524287;
  localparam logic signed [WORD_W-1:0] SAT_MIN = -20'sd524288;

  // Direction order: rest, east, north, west, south, NE, NW, SW, SE.
  localparam int DIR_REST = 0;
  localparam int DIR_E    = 1;
  localparam int DIR_N    = 2;
  localparam int DIR_W    = 3;
  localparam int DIR_S    = 4;
  localparam int DIR_NE   = 5;
  localparam int DIR_NW   = 6;
  localparam int DIR_SW   = 7;
  localparam int DIR_SE   = 8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [NDIR-1:0][WORD_W-1:0] popv_t;

  typedef struct packed {
    logic  fluid;
    popv_t pop;
    word_t rho;
    word_t ux;
    word_t uy;
  } side_t;

  function automatic word_t sat_word(input logic signed [127:0] x);
    word_t r;
    if (x > 128'(SAT_MAX)) r = SAT_MAX;
    else if (x < 128'(SAT_MIN)) r = SAT_MIN;
    else r = x[WORD_W-1:0];
    return r;
  endfunction

  // Lattice vector of direction k dotted with the velocity.
  function automatic logic signed [VEL_W-1:0] dir_dot(input int k, input word_t u,
                                                      input word_t v);
    logic signed [VEL_W-1:0] ue;
    logic signed [VEL_W-1:0] ve;
    logic signed [VEL_W-1:0] r;
    ue = VEL_W'(u);
    ve = VEL_W'(v);
    case (k)
      DIR_E:   r = ue;
      DIR_N:   r = ve;
      DIR_W:   r = -ue;
      DIR_S:   r = -ve;
      DIR_NE:  r = ue + ve;
      DIR_NW:  r = ve - ue;
      DIR_SW:  r = -ue - ve;
      DIR_SE:  r = ue - ve;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/lbm_udiv.sv */
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, one quotient bit per stage, with overflow flag.
module lbm_udiv #(
  parameter int NW = 38,
  parameter int DW = 23,
  parameter int QW = 20
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int EW = NW + DW + QW;

  logic [NW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          ovf_r [QW+1];

  // The quotient does not fit when the dividend reaches the divisor shifted past the top bit.
  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    quo_r[0] <= '0;
    ovf_r[0] <= EW'(num) >= (EW'(den) << QW);
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [EW-1:0] shifted;
    logic          take;
    assign shifted = EW'(den_r[s]) << B;
    assign take    = EW'(rem_r[s]) >= shifted;
    always_ff @(posedge clk) begin
      den_r[s+1] <= den_r[s];
      ovf_r[s+1] <= ovf_r[s];
      rem_r[s+1] <= take ? (rem_r[s] - shifted[NW-1:0]) : rem_r[s];
      quo_r[s+1] <= quo_r[s] | (take ? (QW'(1) << B) : QW'(0));
    end
  end

  assign quo = quo_r[QW];
  assign ovf = ovf_r[QW];

endmodule

/* hw/rtl/lbm_div9.sv */
`timescale 1ns / 1ps
// Pipelined unsigned division by nine, eight quotient bits per stage.
module lbm_div9 #(
  parameter int W = 38
) (
  input  logic         clk,
  input  logic [W-1:0] x,
  output logic [W-1:0] q
);

  localparam int NST = (W + 7) / 8;
  localparam int NB  = NST * 8;

  logic [NB-1:0] sh_r [NST];
  logic [3:0]    rm_r [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [NB-1:0] sh_in;
    logic [3:0]    rm_in;
    logic [NB-1:0] sh;
    logic [3:0]    rm;
    logic [4:0]    t;

    if (s == 0) begin : g_first
      assign sh_in = NB'(x);
      assign rm_in = '0;
    end else begin : g_next
      assign sh_in = sh_r[s-1];
      assign rm_in = rm_r[s-1];
    end

    // The remainder stays below nine, so each step is a five-bit compare and subtract.
    always_comb begin
      sh = sh_in;
      rm = rm_in;
      t  = '0;
      for (int b = 0; b < 8; b++) begin
        t  = {rm, sh[NB-1]};
        sh = {sh[NB-2:0], 1'b0};
        if (t >= 5'd9) begin
          rm    = 4'(t - 5'd9);
          sh[0] = 1'b1;
        end else begin
          rm = t[3:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      sh_r[s] <= sh;
      rm_r[s] <= rm;
    end
  end

  assign q = sh_r[NST-1][W-1:0];

endmodule

/* hw/rtl/lbm_d2q9_bgk_node_update.sv */
`timescale 1ns / 1ps
// Top level of the pipelined D2Q9 lattice Boltzmann BGK node update.
//
// Usage. A node word is presented on is_fluid and the nine pop_* ports and is taken at
// every rising edge at which start is high; busy is always low, so a new node may be
// issued in every cycle. The post-collision populations and the moments of that node
// appear on the new_*, density and velocity_* ports for exactly one cycle, marked by
// done, and must be taken then: the receiver cannot hold the block off, and nothing
// inside ever stalls.
// The pipeline runs the velocity dividers side by side (one quotient bit per stage),
// then the divide-by-nine of the equilibrium weights on words of XW = 68 - 2 * FRAC_BITS
// bits (50 - FRAC_BITS above 18 fraction bits), and otherwise short multiply, add or
// shift stages. Throughput is one node per clock.
// The relaxation rate is written through cfg_valid / cfg_data (cfg_ready is always
// high) and must only change while no node is in flight. Reset loads 1.0 into it and
// clears every valid bit of the pipeline; words in flight are dropped.
// Non-fluid nodes travel down the same pipeline and leave with their populations
// untouched and zero moments, so the output order always matches the input order.
module lbm_d2q9_bgk_node_update #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                is_fluid,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_rest,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_east,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_north,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_west,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_south,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_northeast,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_northwest,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_southwest,
  input  logic signed [lbm_pkg::WORD_W-1:0]   pop_southeast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbm_pkg::OMEGA_W-1:0]         cfg_data,
  output logic                                done,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_rest,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_east,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_north,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_west,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_south,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_northeast,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_northwest,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_southwest,
  output logic signed [lbm_pkg::WORD_W-1:0]   new_southeast,
  output logic signed [lbm_pkg::WORD_W-1:0]   density,
  output logic signed [lbm_pkg::WORD_W-1:0]   velocity_x,
  output logic signed [lbm_pkg::WORD_W-1:0]   velocity_y
);
  import lbm_pkg::*;

  // Widths that follow from the number of fraction bits.
  localparam int F       = FRAC_BITS;
  localparam int NW      = MOM_W - 1 + F;               // |momentum| scaled by one
  localparam int DW      = SUM_W - 1;                   // |full density|
  localparam int DIV_LAT = WORD_W + 1;
  localparam int PW      = ((46 - F) > 28) ? (46 - F) : 28;
  localparam int MW      = WORD_W + PW;
  localparam int XW      = MW + 2 - F;
  localparam int D9_LAT  = (XW + 7) / 8;
  localparam int DFW     = XW + 2;
  localparam int RW      = DFW + OMEGA_W + 1;
  localparam int SL      = 9 + D9_LAT;

  localparam logic signed [ACC_W-1:0] ONE_ACC  = ACC_W'(1) << F;
  localparam logic signed [RW-1:0]    RND_MASK = RW'((1 << OMEGA_FRAC) - 1);

  typedef struct packed {
    side_t side;
    logic  sx;
    logic  sy;
    logic  dz;
  } prep_t;

  function automatic word_t vel_sat(input logic [WORD_W-1:0] q, input logic ovf,
                                    input logic neg, input logic zero);
    logic [WORD_W:0] m;
    logic [WORD_W:0] lim;
    word_t           r;
    m   = ovf ? ((WORD_W+1)'(1) << WORD_W) : {1'b0, q};
    lim = (WORD_W+1)'(1) << (WORD_W - 1);
    if (zero) r = '0;
    else if (neg) r = (m >= lim) ? SAT_MIN : -$signed(m[WORD_W-1:0]);
    else r = (m >= lim) ? SAT_MAX : $signed(m[WORD_W-1:0]);
    return r;
  endfunction

  logic [OMEGA_W-1:0] omega;

  // Stage 1: input register.
  logic  v1;
  side_t side1;

  // Stage 2: moments.
  logic                    v2;
  side_t                   side2;
  logic signed [SUM_W-1:0] rho_full2;
  logic signed [MOM_W-1:0] mx2;
  logic signed [MOM_W-1:0] my2;

  logic signed [WORD_W-1:0] f1 [NDIR];
  logic signed [SUM_W-1:0]  rho_sum;
  logic signed [MOM_W-1:0]  mx_sum;
  logic signed [MOM_W-1:0]  my_sum;

  // Divider section.
  logic [MOM_W-1:0]  mx_abs;
  logic [MOM_W-1:0]  my_abs;
  logic [SUM_W-1:0]  rho_abs;
  logic [NW-1:0]     num_x;
  logic [NW-1:0]     num_y;
  logic [DW-1:0]     den_r;
  logic [WORD_W-1:0] quo_x;
  logic [WORD_W-1:0] quo_y;
  logic              ovf_x;
  logic              ovf_y;
  prep_t             dl [DIV_LAT];
  logic [DIV_LAT-1:0] vdl;

  // Tail of the pipeline: side data and valid bits, one entry per stage.
  side_t         side_q [SL];
  logic [SL-1:0] vl;

  logic signed [VEL_W-1:0]   eu4   [NDIR];
  logic signed [VEL_W-1:0]   eu5   [NDIR];
  logic signed [2*VEL_W-1:0] eusq5 [NDIR];
  logic signed [2*WORD_W-1:0] usq5;
  logic signed [2*WORD_W-1:0] vsq5;
  logic signed [ACC_W-1:0]   lin6  [NDIR];
  logic signed [ACC_W-1:0]   uuh6;
  logic signed [PW-1:0]      poly7 [NDIR];
  logic signed [MW-1:0]      prod8 [NDIR];
  logic [XW-1:0]             x9    [NDIR];
  logic [NDIR-1:0]           neg9;
  logic [XW-1:0]             q9    [NDIR];
  logic [NDIR-1:0]           ng    [D9_LAT];
  logic signed [DFW-1:0]     d10   [NDIR];
  logic signed [RW-1:0]      pr11  [NDIR];
  word_t                     res   [NDIR];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= OMEGA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      omega <= cfg_data;
    end
  end

  // Valid bits: one per stage, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vdl  <= '0;
      vl   <= '0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      vdl  <= {vdl[DIV_LAT-2:0], v2};
      vl   <= {vl[SL-2:0], vdl[DIV_LAT-1]};
      done <= vl[SL-1];
    end
  end

  always_ff @(posedge clk) begin
    side1.fluid        <= is_fluid;
    side1.pop[DIR_REST] <= pop_rest;
    side1.pop[DIR_E]   <= pop_east;
    side1.pop[DIR_N]   <= pop_north;
    side1.pop[DIR_W]   <= pop_west;
    side1.pop[DIR_S]   <= pop_south;
    side1.pop[DIR_NE]  <= pop_northeast;
    side1.pop[DIR_NW]  <= pop_northwest;
    side1.pop[DIR_SW]  <= pop_southwest;
    side1.pop[DIR_SE]  <= pop_southeast;
    side1.rho          <= '0;
    side1.ux           <= '0;
    side1.uy           <= '0;
  end

  // Density and momentum sums.
  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      f1[k] = $signed(side1.pop[k]);
    end
    rho_sum = ((SUM_W'(f1[0]) + SUM_W'(f1[1])) + (SUM_W'(f1[2]) + SUM_W'(f1[3])))
            + ((SUM_W'(f1[4]) + SUM_W'(f1[5])) + (SUM_W'(f1[6]) + SUM_W'(f1[7])))
            + SUM_W'(f1[8]);
    mx_sum  = (MOM_W'(f1[DIR_E]) - MOM_W'(f1[DIR_W]))
            + (MOM_W'(f1[DIR_NE]) - MOM_W'(f1[DIR_NW]))
            + (MOM_W'(f1[DIR_SE]) - MOM_W'(f1[DIR_SW]));
    my_sum  = (MOM_W'(f1[DIR_N]) - MOM_W'(f1[DIR_S]))
            + (MOM_W'(f1[DIR_NE]) + MOM_W'(f1[DIR_NW]))
            - (MOM_W'(f1[DIR_SW]) + MOM_W'(f1[DIR_SE]));
  end

  always_ff @(posedge clk) begin
    side_t s2;
    s2        = side1;
    s2.rho    = sat_word(128'(rho_sum));
    side2     <= s2;
    rho_full2 <= rho_sum;
    mx2       <= mx_sum;
    my2       <= my_sum;
  end

  // Velocity division on magnitudes; the sign is put back afterwards, which gives
  // truncation toward zero.
  assign mx_abs  = mx2[MOM_W-1] ? MOM_W'(-mx2) : MOM_W'(mx2);
  assign my_abs  = my2[MOM_W-1] ? MOM_W'(-my2) : MOM_W'(my2);
  assign rho_abs = rho_full2[SUM_W-1] ? SUM_W'(-rho_full2) : SUM_W'(rho_full2);
  assign num_x   = NW'(mx_abs) << F;
  assign num_y   = NW'(my_abs) << F;
  assign den_r   = rho_abs[DW-1:0];

  lbm_udiv #(.NW(NW), .DW(DW), .QW(WORD_W)) u_div_x (
    .clk (clk),
    .num (num_x),
    .den (den_r),
    .quo (quo_x),
    .ovf (ovf_x)
  );

  lbm_udiv #(.NW(NW), .DW(DW), .QW(WORD_W)) u_div_y (
    .clk (clk),
    .num (num_y),
    .den (den_r),
    .quo (quo_y),
    .ovf (ovf_y)
  );

  always_ff @(posedge clk) begin
    dl[0].side <= side2;
    dl[0].sx   <= mx2[MOM_W-1] ^ rho_full2[SUM_W-1];
    dl[0].sy   <= my2[MOM_W-1] ^ rho_full2[SUM_W-1];
    dl[0].dz   <= (rho_full2 == '0);
    for (int i = 1; i < DIV_LAT; i++) begin
      dl[i] <= dl[i-1];
    end
  end

  // Side data line from the velocity stage to the output.
  always_ff @(posedge clk) begin
    side_t s0;
    s0        = dl[DIV_LAT-1].side;
    s0.ux     = vel_sat(quo_x, ovf_x, dl[DIV_LAT-1].sx, dl[DIV_LAT-1].dz);
    s0.uy     = vel_sat(quo_y, ovf_y, dl[DIV_LAT-1].sy, dl[DIV_LAT-1].dz);
    side_q[0] <= s0;
    for (int i = 1; i < SL; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Equilibrium polynomial: dot products, squares, then the weighted sum.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      eu4[k] <= dir_dot(k, side_q[0].ux, side_q[0].uy);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      eu5[k]   <= eu4[k];
      eusq5[k] <= (eu4[k] * eu4[k]) >>> F;
    end
    usq5 <= $signed(side_q[1].ux) * $signed(side_q[1].ux);
    vsq5 <= $signed(side_q[1].uy) * $signed(side_q[1].uy);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      lin6[k] <= ONE_ACC + 3 * ACC_W'(eu5[k]) + ((9 * ACC_W'(eusq5[k])) >>> 1);
    end
    uuh6 <= (3 * ((ACC_W'(usq5) + ACC_W'(vsq5)) >>> F)) >>> 1;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      poly7[k] <= PW'(lin6[k] - uuh6);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      prod8[k] <= MW'($signed(side_q[4].rho)) * MW'(poly7[k]);
    end
  end

  // Weights: the rest direction carries four ninths, the axes one ninth and the
  // diagonals one thirty-sixth, done as a shift followed by a division by nine.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      logic [MW+1:0] mag;
      mag = prod8[k][MW-1] ? (MW+2)'(-prod8[k]) : (MW+2)'(prod8[k]);
      if (k == DIR_REST) begin
        x9[k] <= XW'((mag << 2) >> F);
      end else if (k >= DIR_NE) begin
        x9[k] <= XW'(mag >> (F + 2));
      end else begin
        x9[k] <= XW'(mag >> F);
      end
      neg9[k] <= prod8[k][MW-1];
    end
  end

  for (genvar k = 0; k < NDIR; k++) begin : g_lane
    lbm_div9 #(.W(XW)) u_div9 (
      .clk (clk),
      .x   (x9[k]),
      .q   (q9[k])
    );
  end

  always_ff @(posedge clk) begin
    ng[0] <= neg9;
    for (int i = 1; i < D9_LAT; i++) begin
      ng[i] <= ng[i-1];
    end
  end

  // Relaxation toward equilibrium.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      logic signed [DFW-1:0] feq;
      feq    = ng[D9_LAT-1][k] ? -$signed(DFW'(q9[k])) : $signed(DFW'(q9[k]));
      d10[k] <= feq - DFW'($signed(side_q[6+D9_LAT].pop[k]));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIR; k++) begin
      pr11[k] <= RW'(d10[k]) * $signed(RW'(omega));
    end
  end

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      logic signed [RW-1:0] relax;
      relax  = (pr11[k] + (pr11[k][RW-1] ? RND_MASK : RW'(0))) >>> OMEGA_FRAC;
      res[k] = sat_word(128'(relax) + 128'($signed(side_q[SL-1].pop[k])));
    end
  end

  // Output register; non-fluid nodes pass their populations and report zero moments.
  always_ff @(posedge clk) begin
    if (side_q[SL-1].fluid) begin
      new_rest      <= res[DIR_REST];
      new_east      <= res[DIR_E];
      new_north     <= res[DIR_N];
      new_west      <= res[DIR_W];
      new_south     <= res[DIR_S];
      new_northeast <= res[DIR_NE];
      new_northwest <= res[DIR_NW];
      new_southwest <= res[DIR_SW];
      new_southeast <= res[DIR_SE];
      density       <= side_q[SL-1].rho;
      velocity_x    <= side_q[SL-1].ux;
      velocity_y    <= side_q[SL-1].uy;
    end else begin
      new_rest      <= $signed(side_q[SL-1].pop[DIR_REST]);
      new_east      <= $signed(side_q[SL-1].pop[DIR_E]);
      new_north     <= $signed(side_q[SL-1].pop[DIR_N]);
      new_west      <= $signed(side_q[SL-1].pop[DIR_W]);
      new_south     <= $signed(side_q[SL-1].pop[DIR_S]);
      new_northeast <= $signed(side_q[SL-1].pop[DIR_NE]);
      new_northwest <= $signed(side_q[SL-1].pop[DIR_NW]);
      new_southwest <= $signed(side_q[SL-1].pop[DIR_SW]);
      new_southeast <= $signed(side_q[SL-1].pop[DIR_SE]);
      density       <= '0;
      velocity_x    <= '0;
      velocity_y    <= '0;
    end
  end

endmodule

/* verif/tb_lbm_d2q9_bgk_node_update.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the pipelined D2Q9 BGK node update.
module tb_lbm_d2q9_bgk_node_update;
  import lbm_pkg::*;

  // Every node gives exactly one result word; the block itself never holds off, so the
  // only gaps come from the sender. Settling waits are taken longer than the pipeline depth.
  localparam int  SETTLE_CYCLES = 64;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  ONE           = 1 << 16;
  localparam int  NRES          = 12;
  localparam int  RES_RHO       = 9;
  localparam int  RES_UX        = 10;
  localparam int  RES_UY        = 11;

  // Lattice vectors and equilibrium weights, in the package's direction order.
  localparam int ex_dir[NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int ey_dir[NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int w_num[NDIR]  = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam int w_den[NDIR]  = '{9, 9, 9, 9, 9, 36, 36, 36, 36};

  typedef struct {
    word_t v[NRES];
  } node_word_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic is_fluid;
  word_t pop_in[NDIR];
  logic cfg_valid;
  logic cfg_ready;
  logic [OMEGA_W-1:0] cfg_data;
  logic done;
  word_t res_out[NRES];

  // Testbench copy of the relaxation rate, updated whenever a write is accepted.
  logic [OMEGA_W-1:0] omega_model;
  node_word_t post_collision_q[$];
  bit failed;
  int unsigned cycle_count;

  lbm_d2q9_bgk_node_update DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .is_fluid(is_fluid),
    .pop_rest(pop_in[0]), .pop_east(pop_in[1]), .pop_north(pop_in[2]),
    .pop_west(pop_in[3]), .pop_south(pop_in[4]), .pop_northeast(pop_in[5]),
    .pop_northwest(pop_in[6]), .pop_southwest(pop_in[7]), .pop_southeast(pop_in[8]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .new_rest(res_out[0]), .new_east(res_out[1]), .new_north(res_out[2]),
    .new_west(res_out[3]), .new_south(res_out[4]), .new_northeast(res_out[5]),
    .new_northwest(res_out[6]), .new_southwest(res_out[7]),
    .new_southeast(res_out[8]), .density(res_out[RES_RHO]),
    .velocity_x(res_out[RES_UX]), .velocity_y(res_out[RES_UY])
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic word_t clamp_word(longint x);
    if (x > longint'(SAT_MAX)) return SAT_MAX;
    if (x < longint'(SAT_MIN)) return SAT_MIN;
    return word_t'(x);
  endfunction

  // Collision of one node: moments, the nine equilibria and BGK relaxation, all in
  // 64-bit integers so that no intermediate product can wrap. SystemVerilog division
  // truncates towards zero, which is the rounding the hardware uses.
  function automatic node_word_t collide_node(bit fluid, word_t p[NDIR],
                                              logic [OMEGA_W-1:0] om);
    node_word_t r;
    longint rho_full, mx, my, rho, ux, uy, uu, eu, eu2, poly, feq, relax;
    rho_full = 0;
    mx = 0;
    my = 0;
    ux = 0;
    uy = 0;
    if (!fluid) begin
      for (int k = 0; k < NDIR; k++) r.v[k] = p[k];
      r.v[RES_RHO] = '0;
      r.v[RES_UX] = '0;
      r.v[RES_UY] = '0;
      return r;
    end
    for (int k = 0; k < NDIR; k++) begin
      rho_full += longint'(p[k]);
      mx += ex_dir[k] * longint'(p[k]);
      my += ey_dir[k] * longint'(p[k]);
    end
    rho = clamp_word(rho_full);
    // Zero density leaves the velocity at rest rather than dividing.
    if (rho_full != 0) begin
      ux = clamp_word((mx * ONE) / rho_full);
      uy = clamp_word((my * ONE) / rho_full);
    end
    uu = (ux * ux + uy * uy) >>> 16;
    for (int k = 0; k < NDIR; k++) begin
      eu = ex_dir[k] * ux + ey_dir[k] * uy;
      eu2 = (eu * eu) >>> 16;
      poly = ONE + 3 * eu + ((9 * eu2) >>> 1) - ((3 * uu) >>> 1);
      feq = (rho * poly * w_num[k]) / (w_den[k] * ONE);
      relax = ((feq - longint'(p[k])) * longint'(om)) / ONE;
      r.v[k] = clamp_word(longint'(p[k]) + relax);
    end
    r.v[RES_RHO] = word_t'(rho);
    r.v[RES_UX] = word_t'(ux);
    r.v[RES_UY] = word_t'(uy);
    return r;
  endfunction

  // Mostly back-to-back words, some short gaps and the odd long one.
  function automatic int pick_gap();
    int d;
    d = $urandom_range(99);
    if (d < 55) return 0;
    if (d < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Issues one node word, holds start until the block takes it, records the expected
  // outcome and then idles for a random gap, which is often none.
  task automatic send_node(bit fluid, word_t p[NDIR]);
    int gap;
    start <= 1'b1;
    is_fluid <= fluid;
    for (int k = 0; k < NDIR; k++) pop_in[k] <= p[k];
    do @(posedge clk); while (busy);
    post_collision_q.push_back(collide_node(fluid, p, omega_model));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops issuing and waits until every outstanding word has come back.
  task automatic drain_nodes();
    start <= 1'b0;
    @(posedge clk);
    while (post_collision_q.size() != 0) @(posedge clk);
  endtask

  // The rate is only changed with the pipeline empty and settled.
  task automatic write_omega(logic [OMEGA_W-1:0] om);
    drain_nodes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= om;
    do @(posedge clk); while (!cfg_ready);
    omega_model = om;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic word_t rand_word();
    return word_t'($urandom());
  endfunction

  // A node near equilibrium: lattice weights at a density around one, plus noise.
  task automatic send_physical_node();
    word_t p[NDIR];
    int scale;
    int noise;
    scale = $urandom_range(2 * ONE, ONE / 4);
    noise = $urandom_range(ONE / 4, 16);
    for (int k = 0; k < NDIR; k++)
      p[k] = word_t'(scale * w_num[k] / w_den[k] + $urandom_range(2 * noise) - noise);
    send_node(1'b1, p);
  endtask

  // A node of wholly random bits; now and then the rest population is chosen so that
  // the density comes out exactly zero.
  task automatic send_raw_node();
    word_t p[NDIR];
    longint s;
    s = 0;
    for (int k = 0; k < NDIR; k++) p[k] = rand_word();
    if ($urandom_range(9) == 0) begin
      for (int k = 1; k < NDIR; k++) p[k] = word_t'($urandom_range(8191)) - 20'sd4096;
      for (int k = 1; k < NDIR; k++) s += longint'(p[k]);
      p[0] = word_t'(-s);
    end
    send_node($urandom_range(5) != 0, p);
  endtask

  task automatic send_fill(bit fluid, word_t val);
    word_t p[NDIR];
    for (int k = 0; k < NDIR; k++) p[k] = val;
    send_node(fluid, p);
  endtask

  // Extremes of every field, pass-through nodes, zero density and saturation.
  task automatic test_directed_nodes();
    word_t p[NDIR];
    send_fill(1'b1, '0);
    send_fill(1'b1, SAT_MAX);
    send_fill(1'b1, SAT_MIN);
    send_fill(1'b0, SAT_MAX);
    send_fill(1'b0, SAT_MIN);
    send_fill(1'b1, 20'sh55555);
    send_fill(1'b1, 20'shAAAAA);
    send_fill(1'b0, 20'sh5A5A5);
    send_fill(1'b1, 20'sd1);
    send_fill(1'b1, -20'sd1);
    // Fluid at rest with unit density sits at its own equilibrium.
    for (int k = 0; k < NDIR; k++) p[k] = word_t'(ONE * w_num[k] / w_den[k]);
    send_node(1'b1, p);
    // Strong flow to the east and to the south-west.
    p[DIR_E] = 20'sd200000;
    send_node(1'b1, p);
    p[DIR_SW] = 20'sd300000;
    send_node(1'b1, p);
    // Zero density with nonzero momentum: the velocity must stay at rest (first node only).
    foreach (p[k]) p[k] = '0;
    p[DIR_E] = 20'sd100000;
    p[DIR_W] = -20'sd100000;
    send_node(1'b1, p);
    p[DIR_E] = 20'sd100000;
    p[DIR_N] = -20'sd100000;
    send_node(1'b1, p);
    // Tiny density against large momentum drives both velocities into saturation.
    foreach (p[k]) p[k] = '0;
    p[DIR_NE] = SAT_MAX;
    p[DIR_REST] = -SAT_MAX + 20'sd1;
    send_node(1'b1, p);
    p[DIR_NE] = SAT_MIN;
    p[DIR_REST] = SAT_MAX;
    p[DIR_SE] = 20'sd2;
    send_node(1'b1, p);
    // Negative density.
    for (int k = 0; k < NDIR; k++) p[k] = -20'sd40000 + word_t'(k * 3000);
    send_node(1'b1, p);
    send_node(1'b0, p);
  endtask

  // A handful of nodes under several rates, the extremes among them.
  task automatic test_omega_extremes();
    logic [OMEGA_W-1:0] rates[4];
    rates = '{17'd0, 17'd131071, 17'd1, 17'd98304};
    foreach (rates[i]) begin
      write_omega(rates[i]);
      send_fill(1'b1, SAT_MAX);
      send_fill(1'b1, 20'sh0F0F0);
      repeat (4) send_physical_node();
      repeat (2) send_raw_node();
    end
  endtask

  // Bulk random traffic in phases with a fresh rate each, mostly well-formed nodes.
  task automatic test_random_nodes();
    for (int phase = 0; phase < 6; phase++) begin
      write_omega(phase == 5 ? OMEGA_RESET : 17'($urandom_range(131071)));
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(99) < 65) send_physical_node();
        else send_raw_node();
      end
    end
  endtask

  // Sender pauses mid-stream until the pipeline has emptied, then carries on.
  task automatic test_drain_pause();
    repeat (30) send_physical_node();
    drain_nodes();
    repeat (30) send_raw_node();
  endtask

  // Every result word is taken at the edge that ends its cycle and compared field by
  // field with the oldest outstanding prediction.
  always @(posedge clk) begin
    node_word_t exp_w;
    if (!rst && done) begin
      if (post_collision_q.size() == 0) begin
        $display("%0t: result word with nothing outstanding", $time);
        failed = 1'b1;
      end else begin
        exp_w = post_collision_q.pop_front();
        for (int k = 0; k < NRES; k++)
          if (res_out[k] !== exp_w.v[k]) begin
            $display("%0t: field %0d expected %0d actual %0d", $time, k, exp_w.v[k],
                     res_out[k]);
            failed = 1'b1;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lbm_d2q9_bgk_node_update verification failed");
      $finish;
    end
  end

  initial begin
    failed = 1'b0;
    cycle_count = 0;
    omega_model = OMEGA_RESET;
    rst = 1'b1;
    start = 1'b0;
    is_fluid = 1'b0;
    foreach (pop_in[k]) pop_in[k] = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_nodes();
    test_omega_extremes();
    test_drain_pause();
    test_random_nodes();
    drain_nodes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("lbm_d2q9_bgk_node_update verification clean");
    end else begin
      $display("lbm_d2q9_bgk_node_update verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lbm_pkg.sv
hw/rtl/lbm_udiv.sv
hw/rtl/lbm_div9.sv
hw/rtl/lbm_d2q9_bgk_node_update.sv
verif/tb_lbm_d2q9_bgk_node_update.sv
